### hw/rtl/frct_pkg.sv
// ----------------------------------------------------------------------------
// frct_pkg - shared types and constants of the fragment receiver
// Verdict codes, header byte positions, CRC-32 step and the records that
// travel between the byte front end, the tracking back end and the queues.
// ----------------------------------------------------------------------------
package frct_pkg;

   // header layout, byte offsets from start of frame
   localparam logic [15:0] POS_ETHER = 16'd12;   // big-endian, two bytes
   localparam logic [15:0] POS_COUNT = 16'd70;   // little-endian fields below
   localparam logic [15:0] POS_INDEX = 16'd72;
   localparam logic [15:0] POS_SIZE  = 16'd74;
   localparam logic [15:0] POS_CRC   = 16'd78;
   localparam logic [15:0] HDR_LEN   = 16'd82;   // first payload byte

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   localparam logic [15:0] ETHER_TYPE_RESET = 16'h1234;
   localparam logic [15:0] MAX_SIZE_RESET   = 16'd1482;

   // configuration register indexes
   localparam logic CSR_ETHER_TYPE = 1'b0;
   localparam logic CSR_MAX_SIZE   = 1'b1;

   // queue depths
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 8;

   typedef enum logic [2:0] {
      V_NEW       = 3'd0,
      V_COMPLETE  = 3'd1,
      V_ETHERTYPE = 3'd2,
      V_CRC       = 3'd3,
      V_OVERSIZE  = 3'd4,
      V_DUPLICATE = 3'd5,
      V_BAD_INDEX = 3'd6,
      V_SHORT     = 3'd7
   } verdict_type;

   // classified frame, front end to back end
   typedef struct packed {
      logic        pass;      // frame passed all frame-local checks
      verdict_type verdict;   // rejection code when pass is low
      logic [15:0] index;
      logic [15:0] count;
      logic [15:0] size;      // saturated size field
   } frag_item_type;

   // one result transaction
   typedef struct packed {
      verdict_type verdict;
      logic [15:0] fragment_number;
      logic [15:0] payload_size;
      logic [31:0] store_offset;
      logic [31:0] total_length;
   } rsp_item_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                              input logic [7:0]  data);
      logic [31:0] c;
      c = crc ^ {24'h0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### hw/rtl/frct_fifo.sv
// ----------------------------------------------------------------------------
// frct_fifo - small register queue
// Show-ahead queue in flip-flops; head data valid while empty is low.
// ----------------------------------------------------------------------------
module frct_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push  = push && (count_ff != CW'(DEPTH));
   assign do_pop   = pop && (count_ff != '0);
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/frct_front.sv
// ----------------------------------------------------------------------------
// frct_front - byte parser, CRC and frame classifier
// Captures header fields and runs CRC-32 byte by byte; at frame end takes a
// snapshot and classifies it against the frame-local checks.
// ----------------------------------------------------------------------------
module frct_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           byte_accept,
   input  logic [7:0]                     frame_byte,
   input  logic                           frame_last,
   input  logic                           csr_write,
   input  logic                           csr_index,
   input  logic [15:0]                    csr_data,
   input  logic [$clog2(frct_pkg::MID_DEPTH+1)-1:0] mid_count,
   output logic                           front_full,
   output logic                           item_push,
   output frct_pkg::frag_item_type        item
);
   import frct_pkg::*;

   logic [15:0] ether_cfg_ff, max_cfg_ff;

   // running frame state
   logic [15:0] pos_ff, pos_in;
   logic [15:0] eth_ff, eth_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [15:0] idx_ff, idx_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] crcf_ff, crcf_in;
   logic [31:0] crc_ff, crc_in;

   // end-of-frame snapshot
   logic        done_ff;
   logic [15:0] s_pos_ff, s_eth_ff, s_cnt_ff, s_idx_ff;
   logic [31:0] s_size_ff, s_crcf_ff, s_crc_ff;

   logic [15:0] pos_inc;
   logic [15:0] pay_off;
   logic [32:0] need_len;
   logic        hdr_short;

   assign front_full = (32'(mid_count) + 32'(done_ff)) >= MID_DEPTH;

   always_comb begin
      eth_in  = eth_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      size_in = size_ff;
      crcf_in = crcf_ff;
      crc_in  = crc_ff;
      pay_off = pos_ff - HDR_LEN;
      unique case (pos_ff)
         POS_ETHER:          eth_in[15:8]   = frame_byte;
         POS_ETHER + 16'd1:  eth_in[7:0]    = frame_byte;
         POS_COUNT:          cnt_in[7:0]    = frame_byte;
         POS_COUNT + 16'd1:  cnt_in[15:8]   = frame_byte;
         POS_INDEX:          idx_in[7:0]    = frame_byte;
         POS_INDEX + 16'd1:  idx_in[15:8]   = frame_byte;
         POS_SIZE:           size_in[7:0]   = frame_byte;
         POS_SIZE + 16'd1:   size_in[15:8]  = frame_byte;
         POS_SIZE + 16'd2:   size_in[23:16] = frame_byte;
         POS_SIZE + 16'd3:   size_in[31:24] = frame_byte;
         POS_CRC:            crcf_in[7:0]   = frame_byte;
         POS_CRC + 16'd1:    crcf_in[15:8]  = frame_byte;
         POS_CRC + 16'd2:    crcf_in[23:16] = frame_byte;
         POS_CRC + 16'd3:    crcf_in[31:24] = frame_byte;
         default: begin
            if (pos_ff >= HDR_LEN && {16'h0, pay_off} < size_ff) begin
               crc_in = crc32_byte(crc_ff, frame_byte);
            end
         end
      endcase
      pos_inc = (pos_ff == 16'hFFFF) ? pos_ff : pos_ff + 16'd1;
      // next frame starts at position zero; header words keep old values until rewritten
      pos_in  = frame_last ? 16'd0 : pos_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ether_cfg_ff <= ETHER_TYPE_RESET;
         max_cfg_ff   <= MAX_SIZE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ETHER_TYPE: ether_cfg_ff <= csr_data;
            CSR_MAX_SIZE:   max_cfg_ff   <= csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         crc_ff  <= CRC_INIT;
         done_ff <= 1'b0;
      end else begin
         done_ff <= byte_accept && frame_last;
         if (byte_accept) begin
            pos_ff <= pos_in;
            crc_ff <= frame_last ? CRC_INIT : crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (byte_accept) begin
         eth_ff    <= eth_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= idx_in;
         size_ff   <= size_in;
         crcf_ff   <= crcf_in;
         s_pos_ff  <= pos_inc;
         s_eth_ff  <= eth_in;
         s_cnt_ff  <= cnt_in;
         s_idx_ff  <= idx_in;
         s_size_ff <= size_in;
         s_crcf_ff <= crcf_in;
         s_crc_ff  <= crc_in;
      end
   end

   // classification of the snapshot, in check order
   assign hdr_short = s_pos_ff < HDR_LEN;
   assign need_len  = 33'(HDR_LEN) + {1'b0, s_size_ff};
   assign item_push = done_ff;

   always_comb begin
      item.pass    = 1'b0;
      item.verdict = V_SHORT;
      item.count   = s_cnt_ff;
      item.index   = hdr_short ? 16'd0 : s_idx_ff;
      if (hdr_short) begin
         item.size = 16'd0;
      end else if (s_size_ff[31:16] != 16'h0) begin
         item.size = 16'hFFFF;
      end else begin
         item.size = s_size_ff[15:0];
      end
      priority if (hdr_short) begin
         item.verdict = V_SHORT;
      end else if (s_eth_ff != ether_cfg_ff) begin
         item.verdict = V_ETHERTYPE;
      end else if ({17'h0, s_pos_ff} < need_len) begin
         item.verdict = V_SHORT;
      end else if (~s_crc_ff != s_crcf_ff) begin
         item.verdict = V_CRC;
      end else if (s_size_ff > {16'h0, max_cfg_ff}) begin
         item.verdict = V_OVERSIZE;
      end else begin
         item.pass    = 1'b1;
         item.verdict = V_NEW;
      end
   end

endmodule

### hw/rtl/frct_back.sv
// ----------------------------------------------------------------------------
// frct_back - fragment tracking pipeline
// Bitmap of received fragments in a memory tagged with a transfer epoch,
// duplicate and completion checks, offset and length products.
// ----------------------------------------------------------------------------
module frct_back #(
   parameter int MAX_FRAGMENTS = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           mid_empty,
   input  frct_pkg::frag_item_type        mid_item,
   output logic                           mid_pop,
   input  logic [$clog2(frct_pkg::OUT_DEPTH+1)-1:0] out_count,
   output logic                           out_push,
   output frct_pkg::rsp_item_type         out_item,
   output logic                           init_busy
);
   import frct_pkg::*;

   localparam int ADDR_W  = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
   // wide enough that the scrubber laps the map before a tag comes back
   localparam int EPOCH_W = $clog2(2 * MAX_FRAGMENTS / 64 + 16) + 1;
   localparam int ENTRY_W = EPOCH_W + 1;
   localparam logic [16:0] MAX_IDX = 17'(MAX_FRAGMENTS);

   logic [ENTRY_W-1:0] map_mem [MAX_FRAGMENTS];
   logic [ENTRY_W-1:0] rd_a_ff, rd_b_ff;

   // write port
   logic               we;
   logic [ADDR_W-1:0]  wa;
   logic [ENTRY_W-1:0] wd;
   logic [ADDR_W-1:0]  ra;

   // tracking state
   logic               started_ff, started_in;
   logic [15:0]        total_ff, total_in;
   logic [15:0]        normal_ff, normal_in;
   logic [15:0]        last_ff, last_in;
   logic [15:0]        rcount_ff, rcount_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;

   // init sweep and scrubber
   logic               init_ff, init_in;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in, ptr_next;
   logic               sc_v_ff;
   logic [ADDR_W-1:0]  sc_addr_ff;
   logic               bw_prev_v_ff;
   logic [ADDR_W-1:0]  bw_prev_addr_ff;
   logic               scrub_need, scrub_we;

   // stage 1: evaluate
   logic               s1_v_ff, s1_fwd_ff;
   frag_item_type      s1_item_ff;
   logic               back_we;
   logic [ADDR_W-1:0]  back_wa;
   logic [15:0]        idx_m1, head_m1;
   logic [15:0]        limit, normal_eff, last_eff, cnt_new;
   logic               bad, bit_set, complete;

   // stage 2: product operands
   logic               s2_v_ff;
   verdict_type        s2_verdict_ff, s2_verdict_in;
   logic [15:0]        s2_index_ff, s2_size_ff;
   logic [15:0]        s2_off_a_ff, s2_off_a_in, s2_off_b_ff, s2_off_b_in;
   logic [15:0]        s2_tot_a_ff, s2_tot_a_in, s2_tot_b_ff, s2_tot_b_in;
   logic [15:0]        s2_tot_c_ff, s2_tot_c_in;

   // stage 3: products
   logic               s3_v_ff;
   verdict_type        s3_verdict_ff;
   logic [15:0]        s3_index_ff, s3_size_ff, s3_tot_c_ff;
   logic [31:0]        s3_off_p_ff, s3_tot_p_ff;

   assign init_busy = init_ff;

   // pop only with room downstream for everything in flight
   assign mid_pop = !mid_empty && !init_ff &&
                    (32'(out_count) + 32'(s1_v_ff) + 32'(s2_v_ff) + 32'(s3_v_ff))
                    < OUT_DEPTH;

   assign head_m1 = mid_item.index - 16'd1;
   assign ra      = head_m1[ADDR_W-1:0];

   // ---- stage 1 evaluation ----
   always_comb begin
      idx_m1     = s1_item_ff.index - 16'd1;
      limit      = started_ff ? total_ff : s1_item_ff.count;
      normal_eff = started_ff ? normal_ff : s1_item_ff.size;
      cnt_new    = rcount_ff + 16'd1;
      last_eff   = (s1_item_ff.index == limit) ? s1_item_ff.size : last_ff;
      complete   = cnt_new >= limit;
      bad        = (s1_item_ff.index == 16'd0) || (s1_item_ff.index > limit) ||
                   ({1'b0, s1_item_ff.index} > MAX_IDX);
      bit_set    = s1_fwd_ff ||
                   (rd_a_ff[EPOCH_W] && (rd_a_ff[EPOCH_W-1:0] == epoch_ff));

      started_in    = started_ff;
      total_in      = total_ff;
      normal_in     = normal_ff;
      last_in       = last_ff;
      rcount_in     = rcount_ff;
      epoch_in      = epoch_ff;
      back_we       = 1'b0;
      back_wa       = idx_m1[ADDR_W-1:0];
      s2_verdict_in = s1_item_ff.verdict;
      s2_off_a_in   = 16'd0;
      s2_off_b_in   = 16'd0;
      s2_tot_a_in   = 16'd0;
      s2_tot_b_in   = 16'd0;
      s2_tot_c_in   = 16'd0;

      if (s1_v_ff && s1_item_ff.pass) begin
         priority if (bad) begin
            s2_verdict_in = V_BAD_INDEX;
         end else if (started_ff && bit_set) begin
            s2_verdict_in = V_DUPLICATE;
         end else begin
            s2_off_a_in = idx_m1;
            s2_off_b_in = normal_eff;
            if (complete) begin
               // transfer done: drop all tracking, map entries go stale
               s2_verdict_in = V_COMPLETE;
               s2_tot_a_in   = limit - 16'd1;
               s2_tot_b_in   = normal_eff;
               s2_tot_c_in   = last_eff;
               started_in    = 1'b0;
               total_in      = 16'd0;
               normal_in     = 16'd0;
               last_in       = 16'd0;
               rcount_in     = 16'd0;
               epoch_in      = epoch_ff + 1'b1;
            end else begin
               s2_verdict_in = V_NEW;
               started_in    = 1'b1;
               total_in      = limit;
               normal_in     = normal_eff;
               last_in       = last_eff;
               rcount_in     = cnt_new;
               back_we       = 1'b1;
            end
         end
      end
   end

   // ---- init sweep, scrubber, write port ----
   always_comb begin
      ptr_next   = (ptr_ff == ADDR_W'(MAX_FRAGMENTS - 1)) ? '0 : ptr_ff + 1'b1;
      // stale = tagged with an older epoch; skip if the back end wrote it
      // in the cycle the scrub read was issued (read returned old data)
      scrub_need = sc_v_ff && rd_b_ff[EPOCH_W] &&
                   (rd_b_ff[EPOCH_W-1:0] != epoch_ff) &&
                   !(bw_prev_v_ff && (bw_prev_addr_ff == sc_addr_ff));
      scrub_we   = scrub_need && !back_we;
      init_in    = init_ff;
      ptr_in     = ptr_next;
      if (init_ff) begin
         if (ptr_ff == ADDR_W'(MAX_FRAGMENTS - 1)) begin
            init_in = 1'b0;
         end
      end else if (scrub_need && back_we) begin
         ptr_in = sc_addr_ff;   // lost the write port, read it again
      end

      we = 1'b0;
      wa = ptr_ff;
      wd = '0;
      priority if (init_ff) begin
         we = 1'b1;
      end else if (back_we) begin
         we = 1'b1;
         wa = back_wa;
         wd = {1'b1, epoch_ff};
      end else if (scrub_we) begin
         we = 1'b1;
         wa = sc_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         map_mem[wa] <= wd;
      end
      rd_a_ff <= map_mem[ra];
      rd_b_ff <= map_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff      <= 1'b1;
         ptr_ff       <= '0;
         sc_v_ff      <= 1'b0;
         bw_prev_v_ff <= 1'b0;
         started_ff   <= 1'b0;
         total_ff     <= '0;
         normal_ff    <= '0;
         last_ff      <= '0;
         rcount_ff    <= '0;
         epoch_ff     <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
      end else begin
         init_ff      <= init_in;
         ptr_ff       <= ptr_in;
         sc_v_ff      <= !init_ff;
         bw_prev_v_ff <= back_we;
         started_ff   <= started_in;
         total_ff     <= total_in;
         normal_ff    <= normal_in;
         last_ff      <= last_in;
         rcount_ff    <= rcount_in;
         epoch_ff     <= epoch_in;
         s1_v_ff      <= mid_pop;
         s2_v_ff      <= s1_v_ff;
         s3_v_ff      <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      sc_addr_ff      <= ptr_ff;
      bw_prev_addr_ff <= back_wa;
      s1_item_ff      <= mid_item;
      s1_fwd_ff       <= back_we && (back_wa == ra);
      s2_verdict_ff   <= s2_verdict_in;
      s2_index_ff     <= s1_item_ff.index;
      s2_size_ff      <= s1_item_ff.size;
      s2_off_a_ff     <= s2_off_a_in;
      s2_off_b_ff     <= s2_off_b_in;
      s2_tot_a_ff     <= s2_tot_a_in;
      s2_tot_b_ff     <= s2_tot_b_in;
      s2_tot_c_ff     <= s2_tot_c_in;
      s3_verdict_ff   <= s2_verdict_ff;
      s3_index_ff     <= s2_index_ff;
      s3_size_ff      <= s2_size_ff;
      s3_tot_c_ff     <= s2_tot_c_ff;
      s3_off_p_ff     <= 32'(s2_off_a_ff) * 32'(s2_off_b_ff);
      s3_tot_p_ff     <= 32'(s2_tot_a_ff) * 32'(s2_tot_b_ff);
   end

   // ---- stage 3 finish ----
   assign out_push                 = s3_v_ff;
   assign out_item.verdict         = s3_verdict_ff;
   assign out_item.fragment_number = s3_index_ff;
   assign out_item.payload_size    = s3_size_ff;
   assign out_item.store_offset    = s3_off_p_ff;
   assign out_item.total_length    = s3_tot_p_ff + 32'(s3_tot_c_ff);

endmodule

### hw/rtl/fragment_receiver_crc_tracker_unit.sv
// ----------------------------------------------------------------------------
// fragment_receiver_crc_tracker_unit - fragment receive tracker with CRC-32
// Checks received fragment frames and tracks which fragments have arrived.
// ----------------------------------------------------------------------------
// Usage:
//  - Frame bytes enter on the req_ queue port, one transaction per byte, in
//    wire order, req_frame_last on the final byte. One byte per cycle is
//    sustained while req_full is low; a payload byte's CRC-32 step completes in that cycle.
//  - Each frame yields exactly one result transaction on the rsp_ queue
//    port: verdict, fragment number, payload size, store offset and, on
//    completion, the total transfer length.
//  - The result is visible (rsp_empty low) once the last byte has gone
//    through classify, map read, evaluate, multiply and add. Back to back
//    frames, even one byte long, give one result per cycle unless a queue
//    stalls; the tracking pipeline issues one map lookup per unstalled cycle.
//  - Stalls: a 4-entry queue sits between the parser and the tracker and an
//    8-entry queue holds results. When rsp_pop stays low the result queue
//    fills, the tracker stops, the middle queue fills and req_full rises.
//  - Reset: configuration goes to ethertype 0x1234 and max size 1482, the
//    frame parser and tracking state clear. The received map is then swept
//    clear, one entry per cycle, over all MAX_FRAGMENTS entries; req_full
//    stays high meanwhile. CSR writes are taken at any time.
// ----------------------------------------------------------------------------
module fragment_receiver_crc_tracker_unit #(
   parameter int MAX_FRAGMENTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // frame byte input
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_frame_last,
   // results
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_verdict,
   output logic [15:0] rsp_fragment_number,
   output logic [15:0] rsp_payload_size,
   output logic [31:0] rsp_store_offset,
   output logic [31:0] rsp_total_length,
   // configuration
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import frct_pkg::*;

   localparam int MID_CW = $clog2(MID_DEPTH + 1);
   localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

   logic                byte_accept;
   logic                front_full;
   logic                init_busy;

   // parser to tracker
   logic                mid_push, mid_pop, mid_empty;
   frag_item_type       mid_in_item, mid_head;
   logic [MID_CW-1:0]   mid_count;

   // tracker to result queue
   logic                out_push, out_empty;
   rsp_item_type        out_in_item, out_head;
   logic [OUT_CW-1:0]   out_count;

   // no input while the map sweep runs
   assign req_full    = front_full || init_busy;
   assign byte_accept = req_push && !req_full;

   frct_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .frame_byte  (req_frame_byte),
      .frame_last  (req_frame_last),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mid_count   (mid_count),
      .front_full  (front_full),
      .item_push   (mid_push),
      .item        (mid_in_item)
   );

   frct_fifo #(
      .WIDTH ($bits(frag_item_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in_item),
      .pop       (mid_pop),
      .pop_data  (mid_head),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   frct_back #(
      .MAX_FRAGMENTS (MAX_FRAGMENTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_item  (mid_head),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_item  (out_in_item),
      .init_busy (init_busy)
   );

   frct_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_in_item),
      .pop       (rsp_pop),
      .pop_data  (out_head),
      .empty     (out_empty),
      .count     (out_count)
   );

   assign rsp_empty           = out_empty;
   assign rsp_verdict         = out_head.verdict;
   assign rsp_fragment_number = out_head.fragment_number;
   assign rsp_payload_size    = out_head.payload_size;
   assign rsp_store_offset    = out_head.store_offset;
   assign rsp_total_length    = out_head.total_length;

   // ---- assertions ----

   // tracker credit keeps the result queue from overflowing
   a_out_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (out_count != OUT_CW'(OUT_DEPTH)) || rsp_pop)
      else $error("result queue overflow");

   // parser stall keeps the middle queue from overflowing
   a_mid_no_overflow: assert property (@(posedge clock) disable iff (reset)
      mid_push |-> (mid_count != MID_CW'(MID_DEPTH)) || mid_pop)
      else $error("middle queue overflow");

   // nothing reaches the tracker during the map sweep
   a_no_pop_in_sweep: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !mid_pop && mid_empty)
      else $error("tracker active during map sweep");

   // a rejected frame carries no offset and no length
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_verdict != V_NEW && rsp_verdict != V_COMPLETE)
      |-> (rsp_store_offset == 32'h0) && (rsp_total_length == 32'h0))
      else $error("rejected frame with nonzero offset or length");

endmodule

### sim/tb_fragment_receiver_crc_tracker_unit.sv
// ----------------------------------------------------------------------------
// tb_fragment_receiver_crc_tracker_unit - fragment receiver self-checking bench
// Feeds whole frames byte by byte through the req_ queue and checks every
// verdict on the rsp_ queue against a cycle-free model of the parser and the
// fragment map. Directed frames cover each rejection path and the transfer
// bookkeeping, then random transfers with shuffled, duplicated and broken
// fragments run without idling under a small max size setting.
// ----------------------------------------------------------------------------
module tb_fragment_receiver_crc_tracker_unit;

   import frct_pkg::*;

   localparam int MAX_FRAGS      = 1024;
   localparam int DRAIN_CYCLES   = 12;     // covers the result pipeline, plus margin
   localparam int SINK_HOLD      = 300;    // receiver hold-off, fills both queues
   localparam int WATCHDOG_LIMIT = 5000;   // covers the post-reset map sweep

   // -------------------------------------------------------------------------
   // Frame model and verdict scoreboard
   // -------------------------------------------------------------------------
   class frag_tracker_model;
      localparam int          SLOTS = MAX_FRAGS;
      localparam logic [31:0] POLY  = 32'hEDB8_8320;

      logic [15:0]  want_ether;
      logic [15:0]  size_limit;
      // per-frame parse state
      logic [15:0]  pos;
      logic [15:0]  hdr_ether, hdr_count, hdr_index;
      logic [31:0]  hdr_size, hdr_crc, crc_acc;
      // transfer tracking
      bit           seen [SLOTS];
      int unsigned  seen_count, total_frags, normal_len, last_len;
      bit           started;
      rsp_item_type pending [$];
      int unsigned  errors;

      function new();
         want_ether = ETHER_TYPE_RESET;
         size_limit = MAX_SIZE_RESET;
         errors     = 0;
         clear_frame();
         clear_tracking();
      endfunction

      function void clear_frame();
         pos       = '0;
         hdr_ether = '0;
         hdr_count = '0;
         hdr_index = '0;
         hdr_size  = '0;
         hdr_crc   = '0;
         crc_acc   = '1;
      endfunction

      function void clear_tracking();
         foreach (seen[i]) seen[i] = 1'b0;
         seen_count  = 0;
         total_frags = 0;
         normal_len  = 0;
         last_len    = 0;
         started     = 1'b0;
      endfunction

      // reflected CRC-32, data bits consumed LSB first
      function logic [31:0] crc_next(logic [31:0] acc, logic [7:0] b);
         logic [31:0] r;
         r = acc;
         for (int i = 0; i < 8; i++) begin
            r = (r >> 1) ^ ((r[0] ^ b[i]) ? POLY : 32'h0);
         end
         return r;
      endfunction

      // one accepted byte; the last byte of a frame queues its verdict
      function void take_byte(logic [7:0] b, logic last);
         rsp_item_type item;
         verdict_type  v;
         logic [15:0]  idx, lim;
         logic [31:0]  sz, offs, tot;
         int unsigned  p;
         p = pos;
         if (p == 12) hdr_ether[15:8] = b;
         else if (p == 13) hdr_ether[7:0] = b;
         else if (p == 70 || p == 71) hdr_count[8*(p-70) +: 8] = b;
         else if (p == 72 || p == 73) hdr_index[8*(p-72) +: 8] = b;
         else if (p >= 74 && p < 78) hdr_size[8*(p-74) +: 8] = b;
         else if (p >= 78 && p < 82) hdr_crc[8*(p-78) +: 8] = b;
         else if (p >= 82 && (p - 82) < hdr_size) crc_acc = crc_next(crc_acc, b);
         if (pos != 16'hFFFF) pos++;
         if (!last) return;

         idx  = hdr_index;
         sz   = hdr_size;
         offs = '0;
         tot  = '0;
         if (pos < 16'd82) begin
            v   = V_SHORT;
            idx = '0;
            sz  = '0;
         end else if (hdr_ether != want_ether) begin
            v = V_ETHERTYPE;
         end else if ({17'd0, pos} < 33'd82 + {1'b0, sz}) begin
            v = V_SHORT;
         end else if (~crc_acc != hdr_crc) begin
            v = V_CRC;
         end else if (sz > {16'd0, size_limit}) begin
            v = V_OVERSIZE;
         end else begin
            // the first accepted frame's own count bounds the index
            lim = started ? total_frags[15:0] : hdr_count;
            if (idx == 0 || idx > lim || idx > SLOTS) begin
               v = V_BAD_INDEX;
            end else if (started && seen[idx-1]) begin
               v = V_DUPLICATE;
            end else begin
               if (!started) begin
                  started     = 1'b1;
                  total_frags = hdr_count;
                  normal_len  = sz;
               end
               seen[idx-1] = 1'b1;
               seen_count++;
               if (idx == total_frags) last_len = sz;
               offs = (32'(idx) - 1) * normal_len;
               if (seen_count >= total_frags) begin
                  v   = V_COMPLETE;
                  tot = (total_frags - 1) * normal_len + last_len;
                  clear_tracking();
               end else begin
                  v = V_NEW;
               end
            end
         end
         item.verdict         = v;
         item.fragment_number = idx;
         item.payload_size    = (sz > 32'hFFFF) ? 16'hFFFF : sz[15:0];
         item.store_offset    = offs;
         item.total_length    = tot;
         pending.push_back(item);
         clear_frame();
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected result v=%0d num=%0d size=%0d off=%0d total=%0d",
                        $time, got.verdict, got.fragment_number, got.payload_size,
                        got.store_offset, got.total_length);
            return;
         end
         want = pending.pop_front();
         if (got.verdict != want.verdict || got.fragment_number != want.fragment_number ||
             got.payload_size != want.payload_size || got.store_offset != want.store_offset ||
             got.total_length != want.total_length) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: result mismatch", $time);
               $display("   expected v=%0d num=%0d size=%0d off=%0d total=%0d",
                        want.verdict, want.fragment_number, want.payload_size,
                        want.store_offset, want.total_length);
               $display("   actual   v=%0d num=%0d size=%0d off=%0d total=%0d",
                        got.verdict, got.fragment_number, got.payload_size,
                        got.store_offset, got.total_length);
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic        clock;
   logic        reset          = 1'b1;
   logic        req_push       = 1'b0;
   logic        req_full;
   logic [7:0]  req_frame_byte = '0;
   logic        req_frame_last = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop        = 1'b0;
   logic [2:0]  rsp_verdict;
   logic [15:0] rsp_fragment_number;
   logic [15:0] rsp_payload_size;
   logic [31:0] rsp_store_offset;
   logic [31:0] rsp_total_length;
   logic        csr_write      = 1'b0;
   logic        csr_index      = CSR_ETHER_TYPE;
   logic [15:0] csr_data       = '0;

   fragment_receiver_crc_tracker_unit #(
      .MAX_FRAGMENTS (MAX_FRAGS)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_frame_byte      (req_frame_byte),
      .req_frame_last      (req_frame_last),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_verdict         (rsp_verdict),
      .rsp_fragment_number (rsp_fragment_number),
      .rsp_payload_size    (rsp_payload_size),
      .rsp_store_offset    (rsp_store_offset),
      .rsp_total_length    (rsp_total_length),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   frag_tracker_model board = new();

   // bench state shared by the driving processes
   logic [15:0] cfg_ether     = ETHER_TYPE_RESET;
   logic [15:0] cfg_max       = MAX_SIZE_RESET;
   int          idle_pct      = 27;      // 0 during the no-idle stretch
   bit          sink_hold_req = 1'b0;    // asks the receiver for a long hold-off
   int unsigned frames_sent   = 0;
   int unsigned bytes_sent    = 0;
   int unsigned quiet_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Monitor: both handshakes are sampled at the edge that completes them
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset) begin
         if (req_push && !req_full) board.take_byte(req_frame_byte, req_frame_last);
         if (rsp_pop && !rsp_empty) begin
            got.verdict         = verdict_type'(rsp_verdict);
            got.fragment_number = rsp_fragment_number;
            got.payload_size    = rsp_payload_size;
            got.store_offset    = rsp_store_offset;
            got.total_length    = rsp_total_length;
            board.check_result(got);
         end
      end
   end

   // Watchdog: ends a run in which neither side moves for too long
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb_fragment_receiver_crc_tracker_unit: done, errors");
         $finish;
      end
   end

   // Result receiver: random pops, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            rsp_pop <= 1'b0;
            repeat (SINK_HOLD) @(posedge clock);
         end
         rsp_pop <= ($urandom_range(99) >= idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------

   // idle a random number of cycles, then offer one byte and hold it until taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_frame_byte <= b;
      req_frame_last <= last;
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   // build a frame: random filler, header fields, pay_len payload bytes with
   // CRC over them; cut_len > 0 truncates the frame to that many bytes
   task automatic send_frame(input logic [15:0] ether, input logic [15:0] count,
                             input logic [15:0] index, input logic [31:0] size,
                             input int pay_len, input bit bad_crc, input int cut_len);
      logic [7:0]  fr [$];
      logic [31:0] crc;
      int          n;
      crc = 32'hFFFF_FFFF;
      repeat (82) fr.push_back(8'($urandom));
      fr[12] = ether[15:8];
      fr[13] = ether[7:0];
      fr[70] = count[7:0];
      fr[71] = count[15:8];
      fr[72] = index[7:0];
      fr[73] = index[15:8];
      for (int k = 0; k < 4; k++) fr[74 + k] = size[8*k +: 8];
      repeat (pay_len) begin
         fr.push_back(8'($urandom));
         crc = board.crc_next(crc, fr[fr.size() - 1]);
      end
      crc = ~crc;
      if (bad_crc) crc ^= 32'h1 << $urandom_range(31);
      for (int k = 0; k < 4; k++) fr[78 + k] = crc[8*k +: 8];
      // trailing bytes beyond the payload must be ignored by the block
      if (pay_len >= size && $urandom_range(4) == 0)
         repeat ($urandom_range(1, 3)) fr.push_back(8'($urandom));
      n = (cut_len > 0) ? cut_len : fr.size();
      for (int k = 0; k < n; k++) send_byte(fr[k], k == n - 1);
      frames_sent++;
   endtask

   // sender stops, all verdicts come back, then the pipeline settles
   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // both registers, back to back; only called while the block is idle
   task automatic program_config(input logic [15:0] ether, input logic [15:0] max_sz);
      csr_write <= 1'b1;
      csr_index <= CSR_ETHER_TYPE;
      csr_data  <= ether;
      @(posedge clock);
      csr_index <= CSR_MAX_SIZE;
      csr_data  <= max_sz;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_ether        = ether;
      cfg_max          = max_sz;
      board.want_ether = ether;
      board.size_limit = max_sz;
   endtask

   function automatic logic [31:0] rand_size();
      logic [31:0] s;
      s = $urandom_range(0, 16);
      return (s > cfg_max) ? {16'd0, cfg_max} : s;
   endfunction

   // one transfer of 1..4 fragments in shuffled order, mixed with duplicates
   // of accepted fragments and broken frames that must leave tracking alone
   task automatic run_transfer();
      logic [15:0] order [$];
      logic [15:0] accepted [$];
      logic [15:0] idx, tmp;
      logic [31:0] sz;
      int          n, j, roll, len;
      n = $urandom_range(1, 4);
      for (int k = 1; k <= n; k++) order.push_back(16'(k));
      for (int k = n - 1; k > 0; k--) begin
         j        = $urandom_range(k);
         tmp      = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      while (order.size() != 0) begin
         roll = $urandom_range(99);
         sz   = rand_size();
         if (roll < 12 && accepted.size() != 0) begin
            idx = accepted[$urandom_range(accepted.size() - 1)];
            send_frame(cfg_ether, 16'(n), idx, sz, sz, 1'b0, 0);
         end else if (roll < 26) begin
            case ($urandom_range(6))
               0: send_frame(cfg_ether, 16'(n), order[0], sz, sz, 1'b0, $urandom_range(1, 81));
               1: send_frame(cfg_ether ^ 16'($urandom_range(1, 65535)), 16'(n), order[0],
                             sz, sz, 1'b0, 0);
               2: begin
                  // payload cut short of the size field
                  sz = $urandom_range(1, 16);
                  send_frame(cfg_ether, 16'(n), order[0], sz, $urandom_range(0, sz - 1),
                             1'b0, 0);
               end
               3: send_frame(cfg_ether, 16'(n), order[0], sz, sz, 1'b1, 0);
               4: begin
                  if (cfg_max < 40) begin
                     sz = cfg_max + $urandom_range(1, 8);
                     send_frame(cfg_ether, 16'(n), order[0], sz, sz, 1'b0, 0);
                  end else begin
                     send_frame(cfg_ether, 16'(n), 16'd0, sz, sz, 1'b0, 0);
                  end
               end
               5: send_frame(cfg_ether, 16'(n), 16'(n + $urandom_range(1, 3)), sz, sz, 1'b0, 0);
               default: begin
                  // pure line noise
                  len = $urandom_range(1, 120);
                  for (int k = 0; k < len; k++) send_byte(8'($urandom), k == len - 1);
                  frames_sent++;
               end
            endcase
         end else begin
            idx = order.pop_front();
            send_frame(cfg_ether, 16'(n), idx, sz, sz, 1'b0, 0);
            accepted.push_back(idx);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      int unsigned start_frames, start_bytes;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: ethertype 0x1234, max size 1482
      send_frame(16'h1234, 16'd3, 16'd1, 32'd0, 0, 1'b0, 1);        // single byte
      send_frame(16'h1234, 16'd3, 16'd1, 32'd0, 0, 1'b0, 81);       // header one short
      send_frame(16'h1235, 16'd3, 16'd1, 32'hFFFF_FFFF, 0, 1'b0, 0); // ethertype, size sat
      send_frame(16'h1234, 16'd3, 16'd1, 32'd10, 5, 1'b0, 0);       // payload short
      send_frame(16'h1234, 16'd3, 16'd1, 32'd6, 6, 1'b1, 0);        // CRC
      send_frame(16'h1234, 16'd3, 16'd0, 32'd4, 4, 1'b0, 0);        // index zero
      send_frame(16'h1234, 16'd2000, 16'd1025, 32'd4, 4, 1'b0, 0);  // beyond map
      // three-fragment transfer; later count fields are ignored
      send_frame(16'h1234, 16'd3, 16'd2, 32'd8, 8, 1'b0, 0);
      send_frame(16'h1234, 16'd3, 16'd2, 32'd8, 8, 1'b0, 0);        // duplicate
      send_frame(16'h1234, 16'd9, 16'd3, 32'd5, 5, 1'b0, 0);        // last fragment
      send_frame(16'h1234, 16'd9, 16'd4, 32'd3, 3, 1'b0, 0);        // above recorded total
      send_frame(16'h1234, 16'd3, 16'd1, 32'd8, 8, 1'b0, 0);        // completes, 21 bytes
      wait_drained();

      // extremes: all-ones ethertype, zero max size
      program_config(16'hFFFF, 16'd0);
      send_frame(16'hFFFF, 16'd1, 16'd1, 32'd1, 1, 1'b0, 0);        // oversize
      send_frame(16'hFFFF, 16'd1, 16'd1, 32'd0, 0, 1'b0, 0);        // one-fragment transfer
      wait_drained();

      // back pressure: receiver holds off while one-byte frames pour in,
      // result and middle queues fill and req_full must rise
      sink_hold_req = 1'b1;
      repeat (40) send_byte(8'($urandom), 1'b1);
      frames_sent += 40;
      wait_drained();

      // random transfers, zero ethertype, small max size, no idling on either side
      program_config(16'h0000, 16'd12);
      idle_pct     = 0;
      start_frames = frames_sent;
      start_bytes  = bytes_sent;
      while (frames_sent - start_frames < 2 || bytes_sent - start_bytes < 150)
         run_transfer();
      wait_drained();

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb_fragment_receiver_crc_tracker_unit: done, clean");
      end else begin
         $display("tb_fragment_receiver_crc_tracker_unit: done, errors");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/frct_pkg.sv
hw/rtl/frct_fifo.sv
hw/rtl/frct_front.sv
hw/rtl/frct_back.sv
hw/rtl/fragment_receiver_crc_tracker_unit.sv
sim/tb_fragment_receiver_crc_tracker_unit.sv
